[src/smes_pkg.sv]
// ----------------------------------------------------------------------------
// smes_pkg
// Shared widths, codes and controller/datapath interface types for the
// sparse matrix entry store.
// ----------------------------------------------------------------------------
package smes_pkg;

    localparam int MAX_DIM_DEF = 16;

    localparam int KIND_W  = 2;
    localparam int INDEX_W = 5;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 9;
    localparam int DIM_W   = 5;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    localparam logic [PADDR_W-3:0] REG_MATRIX_DIM = 1'b0;
    localparam logic [DIM_W-1:0]   DIM_RESET      = 5'd16;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_ITEM  = 2'd1,
        WR_CARRY = 2'd2,
        WR_BACK  = 2'd3
    } wr_sel_t;

    typedef struct packed {
        logic    load_item;
        logic    start;
        logic    clear_all;
        logic    advance;
        wr_sel_t wr_sel;
        logic    load_carry;
        logic    set_found;
        logic    load_rdval;
        logic    len_inc;
        logic    len_dec;
        logic    emit;
    } cmd_t;

    typedef struct packed {
        logic is_write;
        logic is_read;
        logic is_clear;
        logic range_err;
        logic val_zero;
        logic at_end;
        logic col_eq;
        logic col_gt;
        logic row_full;
        logic out_free;
    } status_t;

endpackage

[src/smes_ram.sv]
// ----------------------------------------------------------------------------
// smes_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module smes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/smes_ctrl.sv]
// ----------------------------------------------------------------------------
// smes_ctrl
// Sequencer for one item: decode, row scan, in-place insert or delete shift,
// result handoff.
// ----------------------------------------------------------------------------
module smes_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  smes_pkg::status_t status,
    output smes_pkg::cmd_t    cmd
);
    import smes_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DECODE = 6'b000010,
        ST_FIND   = 6'b000100,
        ST_INS    = 6'b001000,
        ST_DEL    = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        cmd.wr_sel = WR_NONE;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.start = 1'b1;
                if (status.is_clear) begin
                    cmd.clear_all = 1'b1;
                    state_next    = ST_DONE;
                end else if ((status.is_read || status.is_write) && !status.range_err) begin
                    state_next = ST_FIND;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_FIND: begin
                if (status.at_end || status.col_gt) begin
                    if (status.is_read || status.val_zero || status.row_full) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.wr_sel = WR_ITEM;
                        if (status.at_end) begin
                            cmd.len_inc = 1'b1;
                            state_next  = ST_DONE;
                        end else begin
                            cmd.load_carry = 1'b1;
                            cmd.advance    = 1'b1;
                            state_next     = ST_INS;
                        end
                    end
                end else if (status.col_eq) begin
                    cmd.set_found = 1'b1;
                    if (status.is_read) begin
                        cmd.load_rdval = 1'b1;
                        state_next     = ST_DONE;
                    end else if (!status.val_zero) begin
                        cmd.wr_sel = WR_ITEM;
                        state_next = ST_DONE;
                    end else begin
                        cmd.len_dec = 1'b1;
                        cmd.advance = 1'b1;
                        state_next  = ST_DEL;
                    end
                end else begin
                    cmd.advance = 1'b1;
                end
            end
            ST_INS: begin
                cmd.wr_sel = WR_CARRY;
                if (status.at_end) begin
                    cmd.len_inc = 1'b1;
                    state_next  = ST_DONE;
                end else begin
                    cmd.load_carry = 1'b1;
                    cmd.advance    = 1'b1;
                end
            end
            ST_DEL: begin
                if (status.at_end) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.wr_sel  = WR_BACK;
                    cmd.advance = 1'b1;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/smes_dp.sv]
// ----------------------------------------------------------------------------
// smes_dp
// Datapath: item registers, row length table, entry memory, scan pointer,
// shift carry and result register.
// ----------------------------------------------------------------------------
module smes_dp #(
    parameter int MAX_DIM = smes_pkg::MAX_DIM_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [smes_pkg::KIND_W-1:0]          s_kind,
    input  logic [smes_pkg::INDEX_W-1:0]         s_row_index,
    input  logic [smes_pkg::INDEX_W-1:0]         s_col_index,
    input  logic signed [smes_pkg::VALUE_W-1:0]  s_value_in,
    input  logic [smes_pkg::DIM_W-1:0]           dim,
    input  smes_pkg::cmd_t                       cmd,
    output smes_pkg::status_t                    status,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [smes_pkg::VALUE_W-1:0]  m_read_value,
    output logic                                 m_found,
    output logic [smes_pkg::COUNT_W-1:0]         m_nonzero_count,
    output logic                                 m_range_error
);
    import smes_pkg::*;

    localparam int SLOT_W  = $clog2(MAX_DIM);
    localparam int LEN_W   = $clog2(MAX_DIM + 1);
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int AW      = $clog2(DEPTH);
    localparam int TOT_W   = $clog2(DEPTH + 1);
    localparam int DW      = SLOT_W + VALUE_W;
    localparam int DIM_CAP = (MAX_DIM < 31) ? MAX_DIM : 31;

    function automatic logic [AW-1:0] slot_addr(input logic [SLOT_W-1:0] row,
                                                 input logic [SLOT_W-1:0] slot);
        return AW'(row) * AW'(MAX_DIM) + AW'(slot);
    endfunction

    // item
    logic [KIND_W-1:0]         kind_reg;
    logic [INDEX_W-1:0]        row_reg;
    logic [INDEX_W-1:0]        col_reg;
    logic [VALUE_W-1:0]        value_reg;

    // row state
    logic [LEN_W-1:0]          row_len_reg [MAX_DIM];
    logic [TOT_W-1:0]          total_reg;
    logic [LEN_W-1:0]          len_reg;
    logic [LEN_W-1:0]          idx_reg;
    logic [LEN_W-1:0]          idx_next;
    logic [DW-1:0]             carry_reg;

    // result
    logic                      m_valid_reg;
    logic [VALUE_W-1:0]        rdval_reg;
    logic                      found_reg;
    logic                      err_reg;
    logic [VALUE_W-1:0]        out_value_reg;
    logic                      out_found_reg;
    logic [COUNT_W-1:0]        out_count_reg;
    logic                      out_err_reg;

    // decode
    logic [DIM_W-1:0]          dim_eff;
    logic                      range_bad;
    logic                      kind_rw;
    logic [SLOT_W-1:0]         row_sel;
    logic [SLOT_W-1:0]         col_sel;
    logic [INDEX_W-1:0]        row_dec;
    logic [INDEX_W-1:0]        col_dec;

    // memory
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [DW-1:0]             ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [DW-1:0]             ram_rdata;
    logic [SLOT_W-1:0]         rd_slot;
    logic [SLOT_W-1:0]         rd_col;

    assign dim_eff   = (dim > DIM_W'(DIM_CAP)) ? DIM_W'(DIM_CAP) : dim;
    assign range_bad = (row_reg == '0) || (row_reg > dim_eff) ||
                       (col_reg == '0) || (col_reg > dim_eff);
    assign kind_rw   = (kind_reg == KIND_WRITE) || (kind_reg == KIND_READ);
    assign row_dec   = row_reg - INDEX_W'(1);
    assign col_dec   = col_reg - INDEX_W'(1);
    assign row_sel   = range_bad ? '0 : SLOT_W'(row_dec);
    assign col_sel   = SLOT_W'(col_dec);

    always_comb begin
        if (cmd.start) begin
            idx_next = '0;
        end else if (cmd.advance) begin
            idx_next = idx_reg + LEN_W'(1);
        end else begin
            idx_next = idx_reg;
        end
    end

    assign rd_slot   = (idx_next >= LEN_W'(MAX_DIM)) ? '0 : SLOT_W'(idx_next);
    assign ram_raddr = slot_addr(row_sel, rd_slot);
    assign rd_col    = ram_rdata[DW-1 -: SLOT_W];

    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = slot_addr(row_sel, SLOT_W'(idx_reg));
        ram_wdata = ram_rdata;
        case (cmd.wr_sel)
            WR_ITEM: begin
                ram_wdata = {col_sel, value_reg};
            end
            WR_CARRY: begin
                ram_wdata = carry_reg;
            end
            WR_BACK: begin
                ram_waddr = slot_addr(row_sel, SLOT_W'(idx_reg - LEN_W'(1)));
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    smes_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg  <= s_kind;
            row_reg   <= s_row_index;
            col_reg   <= s_col_index;
            value_reg <= s_value_in;
        end
        if (cmd.load_carry) begin
            carry_reg <= ram_rdata;
        end
        if (cmd.start) begin
            err_reg   <= kind_rw && range_bad;
            found_reg <= 1'b0;
            rdval_reg <= '0;
        end
        if (cmd.set_found) begin
            found_reg <= 1'b1;
        end
        if (cmd.load_rdval) begin
            rdval_reg <= ram_rdata[VALUE_W-1:0];
        end
        if (cmd.emit) begin
            out_value_reg <= rdval_reg;
            out_found_reg <= found_reg;
            out_count_reg <= COUNT_W'(total_reg);
            out_err_reg   <= err_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_DIM; i++) begin
                row_len_reg[i] <= '0;
            end
            total_reg   <= '0;
            len_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (cmd.start) begin
                len_reg <= row_len_reg[row_sel];
            end
            if (cmd.clear_all) begin
                for (int i = 0; i < MAX_DIM; i++) begin
                    row_len_reg[i] <= '0;
                end
                total_reg <= '0;
            end else if (cmd.len_inc) begin
                row_len_reg[row_sel] <= len_reg + LEN_W'(1);
                total_reg            <= total_reg + TOT_W'(1);
            end else if (cmd.len_dec) begin
                row_len_reg[row_sel] <= len_reg - LEN_W'(1);
                if (total_reg != '0) begin
                    total_reg <= total_reg - TOT_W'(1);
                end
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign status.is_write  = (kind_reg == KIND_WRITE);
    assign status.is_read   = (kind_reg == KIND_READ);
    assign status.is_clear  = (kind_reg == KIND_CLEAR);
    assign status.range_err = range_bad;
    assign status.val_zero  = (value_reg == '0);
    assign status.at_end    = (idx_reg == len_reg);
    assign status.col_eq    = (rd_col == col_sel);
    assign status.col_gt    = (rd_col > col_sel);
    assign status.row_full  = (len_reg == LEN_W'(MAX_DIM));
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_read_value    = out_value_reg;
    assign m_found         = out_found_reg;
    assign m_nonzero_count = out_count_reg;
    assign m_range_error   = out_err_reg;

    a_idx_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= len_reg)
        else $error("scan pointer passed the row length");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_W'(MAX_DIM))
        else $error("row length above row capacity");

    a_carry_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_sel == WR_CARRY) |-> (len_reg < LEN_W'(MAX_DIM)))
        else $error("insert shift into a full row");

    a_back_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_sel == WR_BACK) |-> (idx_reg != '0) && $past(cmd.advance))
        else $error("delete shift without a preceding slot");

endmodule

[src/sparse_matrix_entry_store_unit.sv]
// ----------------------------------------------------------------------------
// sparse_matrix_entry_store_unit
// Square sparse matrix of signed Q16.16 values kept as per-row sorted
// (column, value) lists, with write, read and clear items.
// ----------------------------------------------------------------------------
// Each item returns one result carrying the running entry count. A read or
// write passes through the decode state, then a scan of the addressed row
// together with any insert or delete shift, and then the load of the output
// register, which waits until the output is free. The scan visits one slot
// per cycle because the row's entries sit in one memory with a single read
// port; a read hit, an in-place update or an early miss ends it before the
// row's end. Clears, out-of-range items and the unused kind go from decode
// straight to the output register load. The next input transfer can follow
// in the cycle after the result is loaded. One item is in work at a time;
// the next item is taken while the previous result still waits in the
// output register. matrix_dim is written through the APB port at byte
// address 0.
module sparse_matrix_entry_store_unit #(
    parameter int MAX_DIM = smes_pkg::MAX_DIM_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [smes_pkg::KIND_W-1:0]          s_kind,
    input  logic [smes_pkg::INDEX_W-1:0]         s_row_index,
    input  logic [smes_pkg::INDEX_W-1:0]         s_col_index,
    input  logic signed [smes_pkg::VALUE_W-1:0]  s_value_in,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [smes_pkg::VALUE_W-1:0]  m_read_value,
    output logic                                 m_found,
    output logic [smes_pkg::COUNT_W-1:0]         m_nonzero_count,
    output logic                                 m_range_error,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [smes_pkg::PADDR_W-1:0]         paddr,
    input  logic [smes_pkg::PDATA_W-1:0]         pwdata,
    output logic [smes_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);
    import smes_pkg::*;

    logic [DIM_W-1:0]     dim_reg;
    logic [PADDR_W-3:0]   reg_index;
    logic                 cfg_write;
    cmd_t                 cmd;
    status_t              status;

    assign pready    = 1'b1;
    assign reg_index = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_reg <= DIM_RESET;
        end else if (cfg_write && (reg_index == REG_MATRIX_DIM)) begin
            dim_reg <= pwdata[DIM_W-1:0];
        end
    end

    assign prdata = (reg_index == REG_MATRIX_DIM) ? PDATA_W'(dim_reg) : '0;

    smes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    smes_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_kind          (s_kind),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_value_in      (s_value_in),
        .dim             (dim_reg),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_value    (m_read_value),
        .m_found         (m_found),
        .m_nonzero_count (m_nonzero_count),
        .m_range_error   (m_range_error)
    );

endmodule
